FILE: src/htc_pkg.sv
package htc_pkg;

  localparam int NUM_STATES_DEFAULT      = 64;
  localparam int MAX_TRANSITIONS_DEFAULT = 128;

  localparam logic [2:0] CMD_ADD_STATE = 3'd0;
  localparam logic [2:0] CMD_ADD_TRANS = 3'd1;
  localparam logic [2:0] CMD_SET_CUR   = 3'd2;
  localparam logic [2:0] CMD_MOVE      = 3'd3;
  localparam logic [2:0] CMD_UNDO      = 3'd4;
  localparam logic [2:0] CMD_QUERY     = 3'd5;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_FULL    = 3'd2;
  localparam logic [2:0] ERR_NOINIT  = 3'd3;
  localparam logic [2:0] ERR_REFUSED = 3'd4;

  // controller -> datapath strobes
  typedef struct packed {
    logic capture;
    logic exec;
    logic walk;
    logic scan;
    logic write2;
    logic load_out;
  } ctl_cmd_t;

  // datapath -> controller flags
  typedef struct packed {
    logic search;
    logic second;
    logic walk_end;
    logic scan_end;
  } ctl_status_t;

endpackage

FILE: src/htc_ram.sv
module htc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/htc_ctrl.sv
module htc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  htc_pkg::ctl_status_t status,
  output htc_pkg::ctl_cmd_t    cmd
);
  import htc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_SCAN,
    S_WRITE2,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.search) begin
          state_next = S_WALK;
        end else if (status.second) begin
          state_next = S_WRITE2;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_end) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_WRITE2: begin
        cmd.write2 = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/htc_datapath.sv
module htc_datapath #(
  parameter int NUM_STATES      = htc_pkg::NUM_STATES_DEFAULT,
  parameter int MAX_TRANSITIONS = htc_pkg::MAX_TRANSITIONS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  htc_pkg::ctl_cmd_t    cmd,
  output htc_pkg::ctl_status_t status,
  input  logic [2:0]           command,
  input  logic [5:0]           state_a,
  input  logic [5:0]           state_b,
  input  logic                 under_root,
  input  logic                 both_ways,
  output logic [2:0]           error_code,
  output logic                 allowed,
  output logic                 current_valid,
  output logic [5:0]           current_state
);
  import htc_pkg::*;

  localparam int SW = $clog2(NUM_STATES);
  localparam int PW = SW + 1;
  localparam int TW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int CW = $clog2(MAX_TRANSITIONS + 1);

  logic [2:0]            cmd_r;
  logic [5:0]            a_r;
  logic [5:0]            b_r;
  logic                  root_r;
  logic                  both_r;

  logic [NUM_STATES-1:0] present;
  logic [NUM_STATES-1:0] mark;
  logic [CW-1:0]         count;
  logic [SW-1:0]         cur;
  logic                  cur_ok;
  logic [SW-1:0]         prev;
  logic                  prev_ok;
  logic [2:0]            err_r;
  logic                  allow_r;
  logic [TW-1:0]         idx;

  logic [SW-1:0]         a_idx;
  logic [SW-1:0]         b_idx;
  logic                  a_rng;
  logic                  b_rng;
  logic                  a_known;
  logic                  b_known;
  logic                  full;
  logic [2:0]            err_exec;

  logic                  p_we;
  logic [PW-1:0]         p_wdata;
  logic [SW-1:0]         p_raddr;
  logic [PW-1:0]         p_rdata;
  logic [SW-1:0]         p_idx;

  logic                  t_we;
  logic [2*SW-1:0]       t_wdata;
  logic [TW-1:0]         t_raddr;
  logic [2*SW-1:0]       t_rdata;
  logic [SW-1:0]         t_from;
  logic [SW-1:0]         t_to;
  logic [CW:0]           idx_inc;
  logic                  hit;

  assign a_idx   = SW'(a_r);
  assign b_idx   = SW'(b_r);
  assign a_rng   = 32'(a_r) < NUM_STATES;
  assign b_rng   = 32'(b_r) < NUM_STATES;
  assign a_known = a_rng && present[a_idx];
  assign b_known = b_rng && present[b_idx];
  assign full    = ((CW+1)'(count) + (both_r ? (CW+1)'(2) : (CW+1)'(1)))
                   > (CW+1)'(MAX_TRANSITIONS);

  always_comb begin
    err_exec = ERR_OK;
    case (cmd_r)
      CMD_ADD_STATE: begin
        if (!a_rng || (!root_r && !b_known)) begin
          err_exec = ERR_UNKNOWN;
        end
      end
      CMD_ADD_TRANS: begin
        if (!a_known || !b_known) begin
          err_exec = ERR_UNKNOWN;
        end else if (full) begin
          err_exec = ERR_FULL;
        end
      end
      CMD_SET_CUR: begin
        if (!a_known) begin
          err_exec = ERR_UNKNOWN;
        end
      end
      CMD_MOVE, CMD_QUERY: begin
        if (!a_known) begin
          err_exec = ERR_UNKNOWN;
        end else if (!cur_ok) begin
          err_exec = ERR_NOINIT;
        end
      end
      default: begin
        err_exec = ERR_OK;
      end
    endcase
  end

  assign status.search   = ((cmd_r == CMD_MOVE) || (cmd_r == CMD_QUERY)) &&
                           (err_exec == ERR_OK);
  assign status.second   = (cmd_r == CMD_ADD_TRANS) && (err_exec == ERR_OK) && both_r;
  assign status.walk_end = 32'(p_rdata) >= NUM_STATES;
  assign status.scan_end = hit || (idx_inc >= {1'b0, count});

  // parent table, root marked by NUM_STATES
  assign p_we    = cmd.exec && (cmd_r == CMD_ADD_STATE) && (err_exec == ERR_OK) &&
                   !present[a_idx];
  assign p_wdata = root_r ? PW'(NUM_STATES) : {1'b0, b_idx};
  assign p_idx   = p_rdata[SW-1:0];
  assign p_raddr = cmd.walk ? p_idx : cur;

  htc_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_STATES)
  ) u_parent_ram (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (a_idx),
    .wr_data (p_wdata),
    .rd_addr (p_raddr),
    .rd_data (p_rdata)
  );

  // transition list, {from, to}
  assign t_we    = (cmd.exec && (cmd_r == CMD_ADD_TRANS) && (err_exec == ERR_OK)) ||
                   cmd.write2;
  assign t_wdata = cmd.write2 ? {b_idx, a_idx} : {a_idx, b_idx};
  assign idx_inc = (CW+1)'(idx) + (CW+1)'(1);
  assign t_raddr = cmd.scan ? idx_inc[TW-1:0] : '0;
  assign t_from  = t_rdata[2*SW-1:SW];
  assign t_to    = t_rdata[SW-1:0];
  assign hit     = (count != '0) && (t_to == a_idx) && mark[t_from];

  htc_ram #(
    .WIDTH (2*SW),
    .DEPTH (MAX_TRANSITIONS)
  ) u_trans_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (count[TW-1:0]),
    .wr_data (t_wdata),
    .rd_addr (t_raddr),
    .rd_data (t_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= command;
      a_r    <= state_a;
      b_r    <= state_b;
      root_r <= under_root;
      both_r <= both_ways;
    end
    if (cmd.exec) begin
      err_r   <= err_exec;
      allow_r <= 1'b0;
      if (status.search) begin
        mark <= NUM_STATES'(1) << cur;
      end
    end
    if (cmd.walk) begin
      if (!status.walk_end) begin
        mark[p_idx] <= 1'b1;
      end else begin
        idx <= '0;
      end
    end
    if (cmd.scan) begin
      idx <= idx_inc[TW-1:0];
      if (status.scan_end) begin
        allow_r <= hit;
        if ((cmd_r == CMD_MOVE) && !hit) begin
          err_r <= ERR_REFUSED;
        end
      end
    end
    if (cmd.load_out) begin
      error_code    <= err_r;
      allowed       <= allow_r;
      current_valid <= cur_ok;
      current_state <= cur_ok ? 6'(cur) : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      count   <= '0;
      cur_ok  <= 1'b0;
      prev_ok <= 1'b0;
      cur     <= '0;
      prev    <= '0;
    end else begin
      if (p_we) begin
        present[a_idx] <= 1'b1;
      end
      if (t_we) begin
        count <= count + CW'(1);
      end
      if (cmd.exec && (err_exec == ERR_OK)) begin
        case (cmd_r)
          CMD_SET_CUR: begin
            cur    <= a_idx;
            cur_ok <= 1'b1;
          end
          CMD_UNDO: begin
            cur    <= prev;
            cur_ok <= prev_ok;
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan && status.scan_end && hit && (cmd_r == CMD_MOVE)) begin
        prev    <= cur;
        prev_ok <= cur_ok;
        cur     <= a_idx;
        cur_ok  <= 1'b1;
      end
    end
  end

endmodule

FILE: src/hierarchical_transition_checker_unit.sv
// Steps: capture, execute, result for add state, set, undo, unused codes;
//   a both-ways add transition writes its second list entry before the result.
// Move/query: after execute, walk the ancestors of the current state (parent RAM walk,
//   one per cycle), then scan list entries (one per cycle, stops on hit, at least 1).
// Throughput: one command at a time; next beat taken once the result is registered.
// Reset: clears presence bits, transition count, current and previous; tables keep data.
module hierarchical_transition_checker_unit #(
  parameter int NUM_STATES      = htc_pkg::NUM_STATES_DEFAULT,
  parameter int MAX_TRANSITIONS = htc_pkg::MAX_TRANSITIONS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [5:0] state_a,
  input  logic [5:0] state_b,
  input  logic       under_root,
  input  logic       both_ways,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] error_code,
  output logic       allowed,
  output logic       current_valid,
  output logic [5:0] current_state
);
  import htc_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  htc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  htc_datapath #(
    .NUM_STATES      (NUM_STATES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .command       (command),
    .state_a       (state_a),
    .state_b       (state_b),
    .under_root    (under_root),
    .both_ways     (both_ways),
    .error_code    (error_code),
    .allowed       (allowed),
    .current_valid (current_valid),
    .current_state (current_state)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted beat did not make the unit busy");

  a_state_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && !current_valid |-> current_state == 6'd0)
    else $error("current_state nonzero with no current state");

  a_allowed_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && allowed |-> error_code == ERR_OK)
    else $error("allowed set on an error result");

  a_load_needs_free_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || !out_stall)
    else $error("result register overwritten while held");

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import htc_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [6:0] ROOT_MARK  = 7'd64;
  localparam int N_STATES    = NUM_STATES_DEFAULT;
  localparam int N_TRANS     = MAX_TRANSITIONS_DEFAULT;
  localparam int NDIR        = 24;
  localparam int RAND_ITEMS  = 950;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 250;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] a;
    logic [5:0] b;
    logic       root;
    logic       both;
  } beat_t;

  typedef struct packed {
    logic [2:0] err;
    logic       allow;
    logic       cv;
    logic [5:0] cs;
  } outcome_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] a;
    logic [5:0] b;
    logic       root;
    logic       both;
    logic       typed;
    logic [2:0] err;
    logic       allow;
    logic       cv;
    logic [5:0] cs;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] command = '0;
  logic [5:0] state_a = '0;
  logic [5:0] state_b = '0;
  logic       under_root = 1'b0;
  logic       both_ways = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] error_code;
  logic       allowed;
  logic       current_valid;
  logic [5:0] current_state;

  // shadow of the block's hierarchy and transition list
  bit         present [N_STATES];
  logic [6:0] parent_of [N_STATES];
  logic [5:0] tr_from [N_TRANS];
  logic [5:0] tr_to [N_TRANS];
  int         tr_count = 0;
  bit         cur_ok = 1'b0;
  logic [5:0] cur = '0;
  bit         prev_ok = 1'b0;
  logic [5:0] prev = '0;
  logic [5:0] known_q [$];

  outcome_t   owed_outcomes [$];
  plan_row_t  plan [NDIR];
  int         cycle_count = 0;
  int         mismatches = 0;
  int         orphans = 0;
  int         checked = 0;
  int         allowed_seen = 0;
  int         code_seen [8];
  int         stall_left = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  outcome_t   got;
  outcome_t   want;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hierarchical_transition_checker_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .state_a(state_a),
    .state_b(state_b),
    .under_root(under_root),
    .both_ways(both_ways),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .error_code(error_code),
    .allowed(allowed),
    .current_valid(current_valid),
    .current_state(current_state)
  );

  function automatic bit is_above(logic [5:0] anc, logic [5:0] s);
    logic [6:0] p;
    p = parent_of[s];
    for (int i = 0; i < N_STATES; i++) begin
      if (p == ROOT_MARK) return 1'b0;
      if (p[5:0] == anc) return 1'b1;
      p = parent_of[p[5:0]];
    end
    return 1'b0;
  endfunction

  function automatic bit reachable(logic [5:0] target);
    for (int i = 0; i < tr_count; i++)
      if (tr_to[i] == target && (tr_from[i] == cur || is_above(tr_from[i], cur)))
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic outcome_t run_command(beat_t bt);
    outcome_t res;
    int need;
    res = '{ERR_OK, 1'b0, 1'b0, 6'd0};
    need = bt.both ? 2 : 1;
    case (bt.cmd)
      CMD_ADD_STATE: begin
        if (!bt.root && !present[bt.b]) begin
          res.err = ERR_UNKNOWN;
        end else if (!present[bt.a]) begin
          present[bt.a] = 1'b1;
          parent_of[bt.a] = bt.root ? ROOT_MARK : {1'b0, bt.b};
          known_q = {known_q, bt.a};
        end
      end
      CMD_ADD_TRANS: begin
        if (!present[bt.a] || !present[bt.b]) begin
          res.err = ERR_UNKNOWN;
        end else if (tr_count + need > N_TRANS) begin
          res.err = ERR_FULL;
        end else begin
          tr_from[tr_count] = bt.a;
          tr_to[tr_count] = bt.b;
          tr_count++;
          if (bt.both) begin
            tr_from[tr_count] = bt.b;
            tr_to[tr_count] = bt.a;
            tr_count++;
          end
        end
      end
      CMD_SET_CUR: begin
        if (!present[bt.a]) begin
          res.err = ERR_UNKNOWN;
        end else begin
          cur = bt.a;
          cur_ok = 1'b1;
        end
      end
      CMD_MOVE, CMD_QUERY: begin
        if (!present[bt.a]) begin
          res.err = ERR_UNKNOWN;
        end else if (!cur_ok) begin
          res.err = ERR_NOINIT;
        end else begin
          res.allow = reachable(bt.a);
          if (bt.cmd == CMD_MOVE) begin
            if (res.allow) begin
              prev = cur;
              prev_ok = cur_ok;
              cur = bt.a;
              cur_ok = 1'b1;
            end else begin
              res.err = ERR_REFUSED;
            end
          end
        end
      end
      CMD_UNDO: begin
        cur = prev;
        cur_ok = prev_ok;
      end
      default: ;
    endcase
    res.cv = cur_ok;
    res.cs = cur_ok ? cur : 6'd0;
    return res;
  endfunction

  // mostly states already placed, some unknown ones
  function automatic logic [5:0] pick_state();
    if (known_q.size() == 0 || $urandom_range(99) < 12) return 6'($urandom_range(63));
    return known_q[$urandom_range(known_q.size() - 1)];
  endfunction

  function automatic beat_t random_beat(int n);
    beat_t bt;
    int r;
    bt.cmd = 3'($urandom_range(7));
    bt.a = 6'($urandom_range(63));
    bt.b = 6'($urandom_range(63));
    bt.root = 1'($urandom_range(1));
    bt.both = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (n < 80 && r < 60) r = 0;
    if (r < 15) begin
      bt.cmd = CMD_ADD_STATE;
      bt.root = (known_q.size() == 0 || $urandom_range(4) == 0);
      bt.b = ($urandom_range(1) && known_q.size() != 0) ? known_q[$] : pick_state();
    end else if (r < 35) begin
      bt.cmd = CMD_ADD_TRANS;
      bt.a = pick_state();
      bt.b = pick_state();
    end else if (r < 43) begin
      bt.cmd = CMD_SET_CUR;
      bt.a = pick_state();
    end else if (r < 93 && !(r >= 68 && r < 78)) begin
      bt.cmd = (r < 68) ? CMD_MOVE : CMD_QUERY;
      if (tr_count != 0 && $urandom_range(1)) bt.a = tr_to[$urandom_range(tr_count - 1)];
      else bt.a = pick_state();
    end else if (r < 78) begin
      bt.cmd = CMD_UNDO;
    end
    return bt;
  endfunction

  function automatic int pick_gap(int n);
    int r;
    if (((n / 64) % 4) == 2) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
               owed_outcomes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{error_code, allowed, current_valid, current_state};
        checked++;
        code_seen[error_code]++;
        if (allowed) allowed_seen++;
        if (owed_outcomes.size() == 0) begin
          orphans++;
          $display("unexpected result beat err=%0d allowed=%0d cur=%0d/%0d",
                   got.err, got.allow, got.cv, got.cs);
        end else begin
          want = owed_outcomes.pop_front();
          if (got.err !== want.err || got.allow !== want.allow ||
              got.cv !== want.cv || got.cs !== want.cs) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: err %0d/%0d allowed %0d/%0d ",
                        "cur_valid %0d/%0d cur %0d/%0d (exp/got)"},
                       checked, want.err, got.err, want.allow, got.allow,
                       want.cv, got.cv, want.cs, got.cs);
          end
        end
      end
      if (hold_req && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (stall_left == 0 && cycle_count[11:10] != 2'b11) begin
        case ($urandom_range(99)) inside
          [0:69]:  stall_left = 0;
          [70:91]: stall_left = $urandom_range(3, 1);
          [92:97]: stall_left = $urandom_range(12, 4);
          default: stall_left = $urandom_range(60, 25);
        endcase
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    beat_t bt;
    plan_row_t rw;
    outcome_t res;
    int gap;
    plan = '{
      '{CMD_MOVE,      6'd5,  6'd0,  1'b0, 1'b0, 1'b1, ERR_UNKNOWN, 1'b0, 1'b0, 6'd0},
      '{CMD_UNDO,      6'd0,  6'd0,  1'b0, 1'b0, 1'b1, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_ADD_STATE, 6'd0,  6'd63, 1'b1, 1'b0, 1'b1, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_ADD_STATE, 6'd63, 6'd0,  1'b0, 1'b0, 1'b1, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_ADD_STATE, 6'd10, 6'd40, 1'b0, 1'b0, 1'b1, ERR_UNKNOWN, 1'b0, 1'b0, 6'd0},
      '{CMD_ADD_STATE, 6'd0,  6'd63, 1'b0, 1'b0, 1'b1, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_QUERY,     6'd63, 6'd0,  1'b0, 1'b0, 1'b1, ERR_NOINIT,  1'b0, 1'b0, 6'd0},
      '{CMD_MOVE,      6'd10, 6'd0,  1'b0, 1'b0, 1'b1, ERR_UNKNOWN, 1'b0, 1'b0, 6'd0},
      '{CMD_ADD_TRANS, 6'd0,  6'd63, 1'b0, 1'b1, 1'b1, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_ADD_TRANS, 6'd5,  6'd0,  1'b0, 1'b0, 1'b1, ERR_UNKNOWN, 1'b0, 1'b0, 6'd0},
      '{CMD_SET_CUR,   6'd63, 6'd0,  1'b0, 1'b0, 1'b1, ERR_OK,      1'b0, 1'b1, 6'd63},
      '{CMD_QUERY,     6'd0,  6'd0,  1'b0, 1'b0, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_ADD_STATE, 6'd20, 6'd63, 1'b0, 1'b0, 1'b1, ERR_OK,      1'b0, 1'b1, 6'd63},
      '{CMD_ADD_STATE, 6'd30, 6'd63, 1'b1, 1'b1, 1'b1, ERR_OK,      1'b0, 1'b1, 6'd63},
      '{CMD_SET_CUR,   6'd20, 6'd0,  1'b0, 1'b0, 1'b1, ERR_OK,      1'b0, 1'b1, 6'd20},
      '{CMD_MOVE,      6'd0,  6'd0,  1'b0, 1'b0, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_MOVE,      6'd30, 6'd0,  1'b0, 1'b0, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_QUERY,     6'd30, 6'd0,  1'b0, 1'b0, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_UNDO,      6'd0,  6'd0,  1'b0, 1'b0, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_UNDO,      6'd63, 6'd63, 1'b1, 1'b1, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_SPARE6,    6'd63, 6'd63, 1'b1, 1'b1, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_SPARE7,    6'd63, 6'd63, 1'b1, 1'b1, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_ADD_TRANS, 6'd30, 6'd30, 1'b0, 1'b1, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0},
      '{CMD_MOVE,      6'd63, 6'd0,  1'b0, 1'b0, 1'b0, ERR_OK,      1'b0, 1'b0, 6'd0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < NDIR + RAND_ITEMS; k++) begin
      rw = plan[k < NDIR ? k : 0];
      if (k < NDIR) bt = '{rw.cmd, rw.a, rw.b, rw.root, rw.both};
      else bt = random_beat(k - NDIR);
      command <= bt.cmd;
      state_a <= bt.a;
      state_b <= bt.b;
      under_root <= bt.root;
      both_ways <= bt.both;
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      res = run_command(bt);
      if (k < NDIR && rw.typed) res = '{rw.err, rw.allow, rw.cv, rw.cs};
      owed_outcomes = {owed_outcomes, res};
      if (k == NDIR + HOLD_AT) hold_req = 1'b1;
      gap = (k < NDIR) ? pick_gap(k) : pick_gap(k - NDIR);
      if (gap > 0 || k == NDIR + RAND_ITEMS - 1) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    while (owed_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display({"%0d commands checked: %0d ok, %0d unknown, %0d full, ",
              "%0d no current, %0d refused"},
             checked, code_seen[ERR_OK], code_seen[ERR_UNKNOWN], code_seen[ERR_FULL],
             code_seen[ERR_NOINIT], code_seen[ERR_REFUSED]);
    $display("%0d moves or queries allowed, %0d states placed, %0d transitions stored",
             allowed_seen, known_q.size(), tr_count);
    if (mismatches == 0 && orphans == 0 && owed_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d unexpected beats", mismatches, orphans);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
src/htc_pkg.sv
src/htc_ram.sv
src/htc_ctrl.sv
src/htc_datapath.sv
src/hierarchical_transition_checker_unit.sv
bench/tb_top.sv
